// ===== sv/convolution_5x5_rgba_unit_macros.svh =====
// Assertion helpers shared by the convolution block.
`ifndef CONVOLUTION_5X5_RGBA_UNIT_MACROS_SVH
`define CONVOLUTION_5X5_RGBA_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CNV5_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CNV5_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/cnv5_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnv5_pkg
// Shared types and fixed constants of the 5x5 RGBA convolution block.
// ----------------------------------------------------------------------------
package cnv5_pkg;

    localparam int N_TAP     = 5;
    localparam int PIX_W     = 8;
    localparam int PIX_MAX   = 255;
    localparam int EDGE_OFS  = -2;
    localparam int FW_W      = 11;
    localparam int FH_W      = 13;
    localparam int BIAS_W    = 11;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_0 = 3'd0,
        CFG_COEF_1 = 3'd1,
        CFG_COEF_2 = 3'd2,
        CFG_COEF_3 = 3'd3,
        CFG_COEF_4 = 3'd4,
        CFG_BIAS   = 3'd5,
        CFG_WIDTH  = 3'd6,
        CFG_HEIGHT = 3'd7
    } t_cfg_idx;

    // Stored pixel, red in the low byte.
    typedef struct packed {
        logic [PIX_W-1:0] alpha;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_pixel;

    // Control that travels with each memory access.
    typedef struct packed {
        logic       valid;
        logic       we;
        logic       first;
        logic       last;
        logic       centre;
        logic [2:0] tr;
        logic [2:0] tc;
    } t_tap_tag;

    // Filtered result of one output pixel.
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
    } t_result;

endpackage

// ===== sv/cnv5_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnv5_in_if
// Input channel: one pixel or drain item per handshake.
// ----------------------------------------------------------------------------
interface cnv5_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;

    modport source (output valid, cmd, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink (input valid, cmd, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// ===== sv/cnv5_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnv5_out_if
// Output channel: one filtered pixel per handshake.
// ----------------------------------------------------------------------------
interface cnv5_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_end;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_end,
                    input ready);
    modport sink (input valid, red_out, green_out, blue_out, alpha_out, frame_end,
                  output ready);
endinterface

// ===== sv/cnv5_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnv5_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module cnv5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 5120
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write or read one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule

// ===== sv/cnv5_addr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnv5_addr
// Three-stage ring address unit: (row * width + col) mod (5 * MAX_WIDTH).
// ----------------------------------------------------------------------------
module cnv5_addr #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cnv5_pkg::t_tap_tag                    i_tag,
    input  logic [(MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1)-1:0] i_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]          i_col,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]        i_w,
    input  cnv5_pkg::t_pixel                      i_pix,
    output cnv5_pkg::t_tap_tag                    o_tag,
    output logic [$clog2(5*MAX_WIDTH)-1:0]        o_addr,
    output cnv5_pkg::t_pixel                      o_pix
);

    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WU_W  = $clog2(MAX_WIDTH + 1);
    localparam int RING  = 5 * MAX_WIDTH;
    localparam int AW    = $clog2(RING);
    localparam int KP_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int K_W   = (KP_W > AW + 1) ? KP_W : AW + 1;
    localparam int RECIP = (2 ** K_W) / RING;
    localparam int RC_W  = $clog2(RECIP + 1);
    localparam int TG_W  = $bits(cnv5_pkg::t_tap_tag);

    cnv5_pkg::t_tap_tag r_tag1, r_tag2;
    cnv5_pkg::t_pixel   r_pix1, r_pix2;
    logic [K_W-1:0]     r_k1, r_k2;
    logic [RC_W-1:0]    r_q;
    logic [ROW_W+WU_W:0] w_k_full;
    logic [K_W+RC_W-1:0] w_qp;
    logic [K_W-1:0]     w_rem;

    // Linear position, then quotient estimate by reciprocal, then remainder.
    assign w_k_full = i_row * i_w + i_col;
    assign w_qp     = r_k1 * RC_W'(RECIP);
    assign w_rem    = r_k2 - K_W'(r_q * RING);

    // Three stages: valid flags are reset, the payload simply follows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
            o_tag.valid  <= 1'b0;
        end else begin
            r_tag1.valid <= i_tag.valid;
            r_tag2.valid <= r_tag1.valid;
            o_tag.valid  <= r_tag2.valid;
        end
        r_tag1[TG_W-2:0] <= i_tag[TG_W-2:0];
        r_pix1 <= i_pix;
        r_k1   <= K_W'(w_k_full);
        r_tag2[TG_W-2:0] <= r_tag1[TG_W-2:0];
        r_pix2 <= r_pix1;
        r_k2   <= r_k1;
        r_q    <= w_qp[K_W +: RC_W];
        o_tag[TG_W-2:0] <= r_tag2[TG_W-2:0];
        o_pix  <= r_pix2;
        if (w_rem >= K_W'(RING)) begin
            o_addr <= AW'(w_rem - K_W'(RING));
        end else begin
            o_addr <= AW'(w_rem);
        end
    end

endmodule

// ===== sv/cnv5_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnv5_mac
// Multiply-accumulate over the 25 taps, then rounding, bias and saturation.
// ----------------------------------------------------------------------------
module cnv5_mac #(
    parameter int COEF_BITS      = 12,
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cnv5_pkg::t_tap_tag                    i_tag,
    input  cnv5_pkg::t_pixel                      i_px,
    input  logic [5*COEF_BITS-1:0]                i_coef [cnv5_pkg::N_TAP],
    input  logic signed [cnv5_pkg::BIAS_W-1:0]    i_bias,
    input  logic                                  i_take,
    output logic                                  o_res_valid,
    output cnv5_pkg::t_result                     o_res
);

    localparam int PR_W  = cnv5_pkg::PIX_W + 1 + COEF_BITS;
    localparam int ACC_W = $clog2(25 * cnv5_pkg::PIX_MAX) + COEF_BITS + 1;
    localparam int V_W   = ACC_W + 1;
    localparam logic [ACC_W-1:0] RND = ACC_W'((1 << COEF_FRAC_BITS) - 1);

    logic signed [COEF_BITS-1:0] w_coef;
    logic signed [PR_W-1:0]      r_prod [3];
    logic signed [ACC_W-1:0]     r_acc [3];
    logic [cnv5_pkg::PIX_W-1:0]  w_ch [3];
    logic [cnv5_pkg::PIX_W-1:0]  r_palpha, r_alpha;
    logic                        r_pvalid, r_pfirst, r_plast, r_pcentre, r_fin;

    // Truncate toward zero, add the bias and saturate to a byte.
    function automatic logic [7:0] f_finish(input logic signed [ACC_W-1:0] a,
                                             input logic signed [cnv5_pkg::BIAS_W-1:0] b);
        logic signed [ACC_W-1:0] adj;
        logic signed [V_W-1:0]   v;
        adj = a[ACC_W-1] ? (a + $signed(RND)) : a;
        v   = V_W'(adj >>> COEF_FRAC_BITS) + V_W'(b);
        if (v < 0) begin
            f_finish = 8'd0;
        end else if (v > V_W'(cnv5_pkg::PIX_MAX)) begin
            f_finish = 8'(cnv5_pkg::PIX_MAX);
        end else begin
            f_finish = v[7:0];
        end
    endfunction

    assign w_coef = $signed(i_coef[i_tag.tr][COEF_BITS*i_tag.tc +: COEF_BITS]);
    assign w_ch[0] = i_px.red;
    assign w_ch[1] = i_px.green;
    assign w_ch[2] = i_px.blue;

    // Control flags of the product, accumulate and finish stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid    <= 1'b0;
            r_fin       <= 1'b0;
            o_res_valid <= 1'b0;
        end else begin
            r_pvalid <= i_tag.valid;
            r_fin    <= r_pvalid && r_plast;
            if (r_fin) begin
                o_res_valid <= 1'b1;
            end else if (i_take) begin
                o_res_valid <= 1'b0;
            end
        end
    end

    // Products of one tap per cycle, then running sums.
    always_ff @(posedge i_clk) begin
        r_pfirst  <= i_tag.first;
        r_plast   <= i_tag.last;
        r_pcentre <= i_tag.centre;
        r_palpha  <= i_px.alpha;
        for (int ch = 0; ch < 3; ch++) begin
            r_prod[ch] <= $signed({1'b0, w_ch[ch]}) * w_coef;
            if (r_pvalid) begin
                if (r_pfirst) begin
                    r_acc[ch] <= ACC_W'(r_prod[ch]);
                end else begin
                    r_acc[ch] <= r_acc[ch] + ACC_W'(r_prod[ch]);
                end
            end
        end
        if (r_pvalid && r_pcentre) begin
            r_alpha <= r_palpha;
        end
        if (r_fin) begin
            o_res.red   <= f_finish(r_acc[0], i_bias);
            o_res.green <= f_finish(r_acc[1], i_bias);
            o_res.blue  <= f_finish(r_acc[2], i_bias);
            o_res.alpha <= r_alpha;
        end
    end

endmodule

// ===== sv/convolution_5x5_rgba_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convolution_5x5_rgba_unit
// Streaming 5x5 RGBA convolution with clamp-to-edge borders.
// ----------------------------------------------------------------------------
// Usage: pixels enter on i_pix in raster order (cmd low); once the whole
// frame is in, drain items (cmd high) push the remaining outputs out. Each
// filtered pixel leaves on o_pix 2*width+2 items after its own input, with
// frame_end high on the last pixel of the frame.
// Configuration is written on i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// Flow: after an item that gives no result the block stays ready for the
// next item. An item that gives a result holds off new items until its result
// is loaded into the output register: the 25 taps are read one per cycle from the
// single-port line store, behind a three-stage address unit, the memory
// read and a three-stage multiply-accumulate.
// All line-store traffic goes through the one memory port, in order, so a
// tap read always sees the write of earlier items.
// Reset restores the identity kernel, zero bias and a 1024 x 1024 frame, and
// clears all positions; the line store is not cleared.
// A finished item waits in the output register while the receiver stalls;
// the next input item is still taken, and the block only holds before
// loading a new result into a full output register.
// ----------------------------------------------------------------------------
`include "convolution_5x5_rgba_unit_macros.svh"

module convolution_5x5_rgba_unit #(
    parameter int MAX_WIDTH      = 1024,
    parameter int MAX_HEIGHT     = 4096,
    parameter int COEF_BITS      = 12,
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    cnv5_in_if.sink                               i_pix,
    cnv5_out_if.source                            o_pix,
    input  logic                                  i_cfg_we,
    input  logic [cnv5_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [((5*COEF_BITS > cnv5_pkg::FH_W) ? 5*COEF_BITS : cnv5_pkg::FH_W)-1:0]
                                                  i_cfg_data
);

    localparam int CR_W    = 5 * COEF_BITS;
    localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WU_W    = $clog2(MAX_WIDTH + 1);
    localparam int HU_W    = $clog2(MAX_HEIGHT + 1);
    localparam int S_W     = ((WU_W > HU_W) ? WU_W : HU_W) + 2;
    localparam int ITEMS_W = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
    localparam int RING    = 5 * MAX_WIDTH;
    localparam int AW      = $clog2(RING);
    localparam logic [CR_W-1:0] COEF_ID =
        CR_W'(1 << COEF_FRAC_BITS) << (2 * COEF_BITS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_TAPS = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state                           r_state;
    logic [CR_W-1:0]                  r_coef [cnv5_pkg::N_TAP];
    logic signed [cnv5_pkg::BIAS_W-1:0] r_bias;
    logic [cnv5_pkg::FW_W-1:0]        r_fw;
    logic [cnv5_pkg::FH_W-1:0]        r_fh;
    logic [ROW_W-1:0]                 r_in_row, r_out_row, r_orow;
    logic [COL_W-1:0]                 r_in_col, r_out_col, r_ocol;
    logic [ITEMS_W-1:0]               r_items;
    logic [2:0]                       r_tr, r_tc;
    logic                             r_fe;
    logic                             r_out_valid;
    cnv5_pkg::t_result                r_out;
    cnv5_pkg::t_tap_tag               r_rd_tag;

    logic [WU_W-1:0]                  w_w;
    logic [HU_W-1:0]                  w_h;
    logic [WU_W+HU_W-1:0]             w_wh;
    logic                             w_acc, w_done, w_do_out, w_load, w_last_px;
    logic signed [S_W-1:0]            w_ri_s, w_ci_s;
    logic [ROW_W-1:0]                 w_ri;
    logic [COL_W-1:0]                 w_ci;
    cnv5_pkg::t_tap_tag               w_tag, w_atag, w_mtag;
    logic [ROW_W-1:0]                 w_arow;
    logic [COL_W-1:0]                 w_acol;
    logic [AW-1:0]                    w_addr;
    cnv5_pkg::t_pixel                 w_in_pix, w_apix, w_rdata;
    logic                             w_res_valid;
    cnv5_pkg::t_result                w_res;

    // Sizes in use, held to their legal ranges.
    always_comb begin
        if (r_fw == '0) begin
            w_w = WU_W'(1);
        end else if (r_fw > cnv5_pkg::FW_W'(MAX_WIDTH)) begin
            w_w = WU_W'(MAX_WIDTH);
        end else begin
            w_w = WU_W'(r_fw);
        end
        if (r_fh == '0) begin
            w_h = HU_W'(1);
        end else if (32'(r_fh) > 32'(MAX_HEIGHT)) begin
            w_h = HU_W'(MAX_HEIGHT);
        end else begin
            w_h = HU_W'(r_fh);
        end
    end

    assign w_wh      = w_w * w_h;
    assign i_pix.ready = (r_state == S_IDLE);
    assign w_acc     = i_pix.valid && i_pix.ready;
    assign w_done    = (32'(r_items) >= 32'(w_wh));
    assign w_do_out  = (!w_done && !i_pix.cmd || w_done) &&
                       (32'(r_items) >= 32'(w_w) * 2 + 2);
    assign w_last_px = (32'(r_out_row) + 1 >= 32'(w_h)) && (32'(r_out_col) + 1 >= 32'(w_w));
    assign w_in_pix  = '{alpha: i_pix.alpha_in, blue: i_pix.blue_in,
                         green: i_pix.green_in, red: i_pix.red_in};

    // Clamped neighbour position of the current tap.
    assign w_ri_s = $signed(S_W'(r_orow)) - S_W'(cnv5_pkg::EDGE_OFS) - $signed(S_W'(r_tr));
    assign w_ci_s = $signed(S_W'(r_ocol)) + S_W'(cnv5_pkg::EDGE_OFS) + $signed(S_W'(r_tc));

    always_comb begin
        if (w_ri_s < 0) begin
            w_ri = '0;
        end else if (w_ri_s > $signed(S_W'(w_h)) - 1) begin
            w_ri = ROW_W'(w_h - HU_W'(1));
        end else begin
            w_ri = ROW_W'(w_ri_s);
        end
        if (w_ci_s < 0) begin
            w_ci = '0;
        end else if (w_ci_s > $signed(S_W'(w_w)) - 1) begin
            w_ci = COL_W'(w_w - WU_W'(1));
        end else begin
            w_ci = COL_W'(w_ci_s);
        end
    end

    // Address unit request: a pixel write on accept, or one tap read.
    always_comb begin
        w_tag  = '0;
        w_arow = r_in_row;
        w_acol = r_in_col;
        if (r_state == S_TAPS) begin
            w_tag.valid  = 1'b1;
            w_tag.first  = (r_tr == 3'd0) && (r_tc == 3'd0);
            w_tag.last   = (r_tr == 3'd4) && (r_tc == 3'd4);
            w_tag.centre = (r_tr == 3'd2) && (r_tc == 3'd2);
            w_tag.tr     = r_tr;
            w_tag.tc     = r_tc;
            w_arow       = w_ri;
            w_acol       = w_ci;
        end else if (w_acc && !w_done && !i_pix.cmd) begin
            w_tag.valid = 1'b1;
            w_tag.we    = 1'b1;
        end
    end

    cnv5_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_tag),
        .i_row   (w_arow),
        .i_col   (w_acol),
        .i_w     (w_w),
        .i_pix   (w_in_pix),
        .o_tag   (w_atag),
        .o_addr  (w_addr),
        .o_pix   (w_apix)
    );

    cnv5_ram #(
        .WIDTH ($bits(cnv5_pkg::t_pixel)),
        .DEPTH (RING)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_en    (w_atag.valid),
        .i_we    (w_atag.we),
        .i_addr  (w_addr),
        .i_wdata (w_apix),
        .o_rdata (w_rdata)
    );

    // Tag is registered alongside the memory read, so it lines up with the read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_tag <= '0;
        end else begin
            r_rd_tag <= w_atag;
        end
    end

    always_comb begin
        w_mtag       = r_rd_tag;
        w_mtag.valid = r_rd_tag.valid && !r_rd_tag.we;
    end

    cnv5_mac #(
        .COEF_BITS      (COEF_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (w_mtag),
        .i_px        (w_rdata),
        .i_coef      (r_coef),
        .i_bias      (r_bias),
        .i_take      (w_load),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    assign w_load = (r_state == S_WAIT) && w_res_valid && (!r_out_valid || o_pix.ready);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < cnv5_pkg::N_TAP; r++) begin
                r_coef[r] <= '0;
            end
            r_coef[2] <= COEF_ID;
            r_bias    <= '0;
            r_fw      <= cnv5_pkg::FW_W'(1024);
            r_fh      <= cnv5_pkg::FH_W'(1024);
        end else if (i_cfg_we) begin
            case (cnv5_pkg::t_cfg_idx'(i_cfg_idx))
                cnv5_pkg::CFG_COEF_0: r_coef[0] <= CR_W'(i_cfg_data);
                cnv5_pkg::CFG_COEF_1: r_coef[1] <= CR_W'(i_cfg_data);
                cnv5_pkg::CFG_COEF_2: r_coef[2] <= CR_W'(i_cfg_data);
                cnv5_pkg::CFG_COEF_3: r_coef[3] <= CR_W'(i_cfg_data);
                cnv5_pkg::CFG_COEF_4: r_coef[4] <= CR_W'(i_cfg_data);
                cnv5_pkg::CFG_BIAS:   r_bias    <= cnv5_pkg::BIAS_W'(i_cfg_data);
                cnv5_pkg::CFG_WIDTH:  r_fw      <= cnv5_pkg::FW_W'(i_cfg_data);
                cnv5_pkg::CFG_HEIGHT: r_fh      <= cnv5_pkg::FH_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Sequencer and frame positions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_items   <= '0;
            r_tr      <= '0;
            r_tc      <= '0;
            r_fe      <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc && (w_done || !i_pix.cmd)) begin
                        r_items <= r_items + ITEMS_W'(1);
                        if (!w_done) begin
                            if (32'(r_in_col) + 1 >= 32'(w_w)) begin
                                r_in_col <= '0;
                                r_in_row <= (32'(r_in_row) + 1 >= 32'(w_h)) ? '0 :
                                            r_in_row + ROW_W'(1);
                            end else begin
                                r_in_col <= r_in_col + COL_W'(1);
                            end
                        end
                        if (w_do_out) begin
                            r_orow  <= r_out_row;
                            r_ocol  <= r_out_col;
                            r_fe    <= w_last_px;
                            r_tr    <= '0;
                            r_tc    <= '0;
                            r_state <= S_TAPS;
                            if (w_last_px) begin
                                r_in_row  <= '0;
                                r_in_col  <= '0;
                                r_out_row <= '0;
                                r_out_col <= '0;
                                r_items   <= '0;
                            end else if (32'(r_out_col) + 1 >= 32'(w_w)) begin
                                r_out_col <= '0;
                                r_out_row <= (32'(r_out_row) + 1 >= 32'(w_h)) ? '0 :
                                             r_out_row + ROW_W'(1);
                            end else begin
                                r_out_col <= r_out_col + COL_W'(1);
                            end
                        end
                    end
                end
                S_TAPS: begin
                    if (r_tc == 3'd4) begin
                        r_tc <= '0;
                        r_tr <= r_tr + 3'd1;
                        if (r_tr == 3'd4) begin
                            r_state <= S_WAIT;
                        end
                    end else begin
                        r_tc <= r_tc + 3'd1;
                    end
                end
                S_WAIT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out           <= w_res;
            o_pix.frame_end <= r_fe;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.red_out   = r_out.red;
    assign o_pix.green_out = r_out.green;
    assign o_pix.blue_out  = r_out.blue;
    assign o_pix.alpha_out = r_out.alpha;

    // A result is loaded only into a free output register.
    `CNV5_ASSERT_IMP(a_load_free, i_clk, i_rst_n, w_load,
        (!r_out_valid || o_pix.ready), "output register overwritten")
    // An item that produces a result starts the tap sweep next cycle.
    `CNV5_ASSERT_NXT(a_sweep_start, i_clk, i_rst_n, (w_acc && w_do_out),
        (r_state == S_TAPS && r_tr == 3'd0 && r_tc == 3'd0), "tap sweep not started")
    // No new item is taken while a result waits inside the datapath.
    `CNV5_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, w_acc, !w_res_valid,
        "item accepted while result pending")
    // Tap reads never reach the memory as writes.
    `CNV5_ASSERT_IMP(a_tap_read, i_clk, i_rst_n, (r_state == S_TAPS),
        (!w_tag.we && w_tag.valid), "tap issued as write")

endmodule

// ===== dv/cnv5_conv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnv5_conv_checker
// Watches the pixel channels and the register port of the 5x5 convolution
// block, predicts every filtered pixel and compares it with what leaves.
// ----------------------------------------------------------------------------
module cnv5_conv_checker
    import cnv5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cnv5_in_if          i_pix_mon,
    cnv5_out_if         i_res_mon,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [59:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    localparam int MAX_W     = 1024;
    localparam int MAX_H     = 4096;
    localparam int RING      = 5 * MAX_W;
    localparam int CBITS     = 12;
    localparam int FRAC      = 8;
    localparam int SEEN_MASK = 32'h7F_FFFF;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       frame_end;
    } filt_px_t;

    // Predicted copy of the block's registers and positions.
    logic [59:0]       kernel_row [N_TAP];
    logic [BIAS_W-1:0] bias_reg;
    logic [FW_W-1:0]   width_reg;
    logic [FH_W-1:0]   height_reg;
    logic [31:0]       pix_ring [RING];
    int                in_y, in_x, out_y, out_x, counted;
    filt_px_t          filt_queue [$];

    assign o_pending = filt_queue.size();

    function automatic int clamp_to(int v, int n);
        if (v < 0) return 0;
        if (v > n - 1) return n - 1;
        return v;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d (result %0d)",
                 what, got, want, o_checked);
        o_fail_count++;
    endtask

    // Advance the prediction by one accepted item.
    task automatic predict_item(logic cmd, logic [31:0] word);
        int w, h, n, sum, v, ry, cx;
        logic [31:0] tap;
        filt_px_t px;
        w = clamp_to(width_reg, MAX_W + 1);
        if (w < 1) w = 1;
        h = clamp_to(height_reg, MAX_H + 1);
        if (h < 1) h = 1;
        if (counted < w * h) begin
            // Drain items are ignored until the whole frame is in.
            if (cmd) return;
            pix_ring[(in_y * w + in_x) % RING] = word;
            if (in_x + 1 >= w) begin
                in_x = 0;
                in_y = (in_y + 1 >= h) ? 0 : in_y + 1;
            end else begin
                in_x++;
            end
        end
        n = counted;
        counted = (counted + 1) & SEEN_MASK;
        if (n < 2 * w + 2) return;
        for (int ch = 0; ch < 3; ch++) begin
            sum = 0;
            for (int r = 0; r < N_TAP; r++) begin
                // Kernel rows are flipped against the image, columns are not.
                ry = clamp_to(out_y + 2 - r, h);
                for (int c = 0; c < N_TAP; c++) begin
                    cx = clamp_to(out_x - 2 + c, w);
                    tap = pix_ring[(ry * w + cx) % RING];
                    sum += int'(tap[8*ch +: 8]) * int'($signed(kernel_row[r][CBITS*c +: CBITS]));
                end
            end
            v = sum / (1 << FRAC) + int'($signed(bias_reg));
            if (v > PIX_MAX) v = PIX_MAX;
            if (v < 0) v = 0;
            case (ch)
                0: px.red = v[7:0];
                1: px.green = v[7:0];
                default: px.blue = v[7:0];
            endcase
        end
        tap = pix_ring[(clamp_to(out_y, h) * w + clamp_to(out_x, w)) % RING];
        px.alpha = tap[31:24];
        if (out_y + 1 >= h && out_x + 1 >= w) begin
            px.frame_end = 1'b1;
            in_y = 0; in_x = 0; out_y = 0; out_x = 0; counted = 0;
        end else begin
            px.frame_end = 1'b0;
            if (out_x + 1 >= w) begin
                out_x = 0;
                out_y = (out_y + 1 >= h) ? 0 : out_y + 1;
            end else begin
                out_x++;
            end
        end
        filt_queue.push_back(px);
    endtask

    // Compare one accepted result with the oldest prediction.
    task automatic check_result();
        filt_px_t want;
        if (filt_queue.size() == 0) begin
            $display("unexpected result with nothing predicted");
            o_fail_count++;
            return;
        end
        want = filt_queue.pop_front();
        if (i_res_mon.red_out !== want.red)
            report_mismatch("red", i_res_mon.red_out, want.red);
        if (i_res_mon.green_out !== want.green)
            report_mismatch("green", i_res_mon.green_out, want.green);
        if (i_res_mon.blue_out !== want.blue)
            report_mismatch("blue", i_res_mon.blue_out, want.blue);
        if (i_res_mon.alpha_out !== want.alpha)
            report_mismatch("alpha", i_res_mon.alpha_out, want.alpha);
        if (i_res_mon.frame_end !== want.frame_end)
            report_mismatch("frame_end", i_res_mon.frame_end, want.frame_end);
        o_checked++;
    endtask

    initial begin
        o_fail_count = 0;
        o_checked = 0;
    end

    // Everything is sampled at the rising edge; results are checked before
    // the item of the same edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < N_TAP; r++) kernel_row[r] = '0;
            kernel_row[2] = 60'h1 << (FRAC + 2 * CBITS);
            bias_reg = '0;
            width_reg = 11'd1024;
            height_reg = 13'd1024;
            in_y = 0; in_x = 0; out_y = 0; out_x = 0; counted = 0;
            filt_queue.delete();
        end else begin
            if (i_res_mon.valid && i_res_mon.ready) check_result();
            if (i_pix_mon.valid && i_pix_mon.ready)
                predict_item(i_pix_mon.cmd, {i_pix_mon.alpha_in, i_pix_mon.blue_in,
                                             i_pix_mon.green_in, i_pix_mon.red_in});
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_COEF_0: kernel_row[0] = i_cfg_data;
                    CFG_COEF_1: kernel_row[1] = i_cfg_data;
                    CFG_COEF_2: kernel_row[2] = i_cfg_data;
                    CFG_COEF_3: kernel_row[3] = i_cfg_data;
                    CFG_COEF_4: kernel_row[4] = i_cfg_data;
                    CFG_BIAS:   bias_reg = i_cfg_data[BIAS_W-1:0];
                    CFG_WIDTH:  width_reg = i_cfg_data[FW_W-1:0];
                    default:    height_reg = i_cfg_data[FH_W-1:0];
                endcase
            end
        end
    end

endmodule

// ===== dv/tb_convolution_5x5_rgba_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_convolution_5x5_rgba_unit
// Streams whole frames of random pixels through the convolution block under
// varied kernels, biases and frame sizes, with random idling on both sides,
// while a checker predicts and compares every filtered pixel.
// ----------------------------------------------------------------------------
module tb_convolution_5x5_rgba_unit;
    import cnv5_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [59:0] cfg_data;
    int          fail_count, pending, checked;
    int          items_sent, frames_run;
    int          src_idle, snk_idle;

    cnv5_in_if  pix_ch ();
    cnv5_out_if res_ch ();

    convolution_5x5_rgba_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_ch),
        .o_pix      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    cnv5_conv_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_mon    (pix_ch),
        .i_res_mon    (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Safety net against a hung handshake.
    initial begin
        #40ms;
        $display("== FAIL ==");
        $finish;
    end

    // The receiver stalls at random according to the current phase.
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= snk_idle);
    end

    function automatic logic [7:0] rand_byte();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return 8'h00;
        if (sel == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // Idling follows the item count: receiver mostly idle, then sender, then neither.
    task automatic push_item(logic cmd);
        src_idle = (items_sent < 700) ? 26 : (items_sent < 1400) ? 85 : 0;
        snk_idle = (items_sent < 700) ? 85 : (items_sent < 1400) ? 26 : 0;
        while ($urandom_range(99) < src_idle) begin
            pix_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.cmd      <= cmd;
        pix_ch.red_in   <= rand_byte();
        pix_ch.green_in <= rand_byte();
        pix_ch.blue_in  <= rand_byte();
        pix_ch.alpha_in <= rand_byte();
        do @(posedge i_clk); while (!pix_ch.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [59:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [59:0] pack_row(int c0, int c1, int c2, int c3, int c4);
        logic [11:0] t0, t1, t2, t3, t4;
        t0 = 12'(c0); t1 = 12'(c1); t2 = 12'(c2); t3 = 12'(c3); t4 = 12'(c4);
        return {t4, t3, t2, t1, t0};
    endfunction

    // Mostly modest taps so that results spread over the range, some extremes.
    function automatic logic [59:0] rand_row();
        logic [59:0] row;
        int sel;
        for (int c = 0; c < N_TAP; c++) begin
            sel = $urandom_range(9);
            if (sel < 6) row[12*c +: 12] = 12'($signed($urandom_range(160)) - 80);
            else if (sel == 6) row[12*c +: 12] = 12'h800;
            else if (sel == 7) row[12*c +: 12] = 12'h7FF;
            else row[12*c +: 12] = 12'($urandom_range(4095));
        end
        return row;
    endfunction

    // One frame: its pixels with stray drains, then the flushing tail.
    task automatic run_frame(int wreg, int hreg);
        int w, h;
        w = (wreg < 1) ? 1 : (wreg > 1024) ? 1024 : wreg;
        h = (hreg < 1) ? 1 : (hreg > 4096) ? 4096 : hreg;
        write_reg(CFG_WIDTH, 60'(wreg));
        write_reg(CFG_HEIGHT, 60'(hreg));
        for (int k = 0; k < w * h; k++) begin
            if ($urandom_range(19) == 0) push_item(1'b1);
            push_item(1'b0);
        end
        // Pixels sent once the frame is in act as drains.
        for (int k = 0; k < 2 * w + 2; k++) push_item($urandom_range(3) != 0);
        // The last item has gone; the channel falls quiet until the next frame.
        pix_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        frames_run++;
    endtask

    task automatic write_kernel(logic [59:0] r0, r1, r2, r3, r4, int bias);
        write_reg(CFG_COEF_0, r0);
        write_reg(CFG_COEF_1, r1);
        write_reg(CFG_COEF_2, r2);
        write_reg(CFG_COEF_3, r3);
        write_reg(CFG_COEF_4, r4);
        write_reg(CFG_BIAS, 60'(bias));
    endtask

    initial begin
        logic [59:0] ident;
        pix_ch.valid = 1'b0;
        pix_ch.cmd = 1'b0;
        pix_ch.red_in = '0;
        pix_ch.green_in = '0;
        pix_ch.blue_in = '0;
        pix_ch.alpha_in = '0;
        res_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_COEF_0;
        cfg_data = '0;
        items_sent = 0;
        frames_run = 0;
        src_idle = 0;
        snk_idle = 0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Kernel as left by reset, on a frame narrower than the kernel.
        run_frame(3, 2);
        // Largest taps and bias drive saturation high on a single pixel.
        ident = pack_row(12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF);
        write_kernel(ident, ident, ident, ident, ident, 1023);
        run_frame(1, 1);
        // Most negative taps and bias, with zero sizes held to one.
        ident = pack_row(12'h800, 12'h800, 12'h800, 12'h800, 12'h800);
        write_kernel(ident, ident, ident, ident, ident, -1024);
        run_frame(0, 0);

        // Random kernels and small frames.
        while (items_sent < 2000) begin
            write_kernel(rand_row(), rand_row(), rand_row(), rand_row(), rand_row(),
                         ($urandom_range(3) == 0) ? $urandom_range(2047) - 1024
                                                  : $urandom_range(40) - 20);
            run_frame($urandom_range(4) == 0 ? $urandom_range(20, 1) : $urandom_range(8, 1),
                      $urandom_range(8, 1));
        end

        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        $display("Ran %0d frames from %0d input items; %0d filtered pixels checked.",
                 frames_run, items_sent, checked);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches found.", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== convolution_5x5_rgba_unit.f =====
+incdir+sv
sv/cnv5_pkg.sv
sv/cnv5_in_if.sv
sv/cnv5_out_if.sv
sv/cnv5_ram.sv
sv/cnv5_addr.sv
sv/cnv5_mac.sv
sv/convolution_5x5_rgba_unit.sv
dv/cnv5_conv_checker.sv
dv/tb_convolution_5x5_rgba_unit.sv
